// ===== rtl/ppls_pkg.sv =====
// Shared constants, types and helpers of the Phong point-light shader.
package ppls_pkg;

   localparam int MAX_LIGHTS  = 8;
   localparam int LIGHT_IW    = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int LCNT_W      = $clog2(MAX_LIGHTS + 1);
   localparam int TABLE_AW    = LIGHT_IW + 2;
   localparam int TABLE_DEPTH = MAX_LIGHTS * 4;

   localparam int SQRT_STEPS = 30;
   localparam int DIV_STEPS  = 16;
   localparam int POW_STEPS  = 8;

   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_MAT_AMBIENT   = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_MAT_DIFFUSE   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_MAT_SPECULAR  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_SHININESS     = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_VIEW_POSITION = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_LIGHT_COUNT   = 3'd5;

   localparam logic OPERATION_TABLE_WRITE = 1'b0;
   localparam logic OPERATION_SHADE       = 1'b1;

   localparam logic [1:0] WORD_POSITION = 2'd0;
   localparam logic [1:0] WORD_AMBIENT  = 2'd1;
   localparam logic [1:0] WORD_DIFFUSE  = 2'd2;
   localparam logic [1:0] WORD_SPECULAR = 2'd3;

   localparam logic [1:0] VSEL_NORMAL = 2'd0;
   localparam logic [1:0] VSEL_VIEW   = 2'd1;
   localparam logic [1:0] VSEL_LIGHT  = 2'd2;

   localparam logic [4:0] OP_NOP        = 5'd0;
   localparam logic [4:0] OP_TABLE_WR   = 5'd1;
   localparam logic [4:0] OP_LOAD_FRAG  = 5'd2;
   localparam logic [4:0] OP_SET_VIEW   = 5'd3;
   localparam logic [4:0] OP_SET_LIGHT  = 5'd4;
   localparam logic [4:0] OP_SQUARE     = 5'd5;
   localparam logic [4:0] OP_SQRT_INIT  = 5'd6;
   localparam logic [4:0] OP_SQRT_STEP  = 5'd7;
   localparam logic [4:0] OP_DIV_INIT   = 5'd8;
   localparam logic [4:0] OP_DIV_STEP   = 5'd9;
   localparam logic [4:0] OP_DIV_STORE  = 5'd10;
   localparam logic [4:0] OP_READ       = 5'd11;
   localparam logic [4:0] OP_DOT        = 5'd12;
   localparam logic [4:0] OP_DIFF       = 5'd13;
   localparam logic [4:0] OP_REFL       = 5'd14;
   localparam logic [4:0] OP_SPEC_DOT   = 5'd15;
   localparam logic [4:0] OP_POW_INIT   = 5'd16;
   localparam logic [4:0] OP_POW_STEP   = 5'd17;
   localparam logic [4:0] OP_AMB_TERM   = 5'd18;
   localparam logic [4:0] OP_DIF_COLOR  = 5'd19;
   localparam logic [4:0] OP_DIF_TERM   = 5'd20;
   localparam logic [4:0] OP_SPC_COLOR  = 5'd21;
   localparam logic [4:0] OP_SPC_TERM   = 5'd22;
   localparam logic [4:0] OP_OUTPUT     = 5'd23;

   typedef struct packed {
      logic              operation;
      logic [2:0]        light_index;
      logic [1:0]        light_word;
      logic [47:0]       light_value;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] frag_x;
      logic signed [15:0] frag_y;
      logic signed [15:0] frag_z;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [4:0]          op;
      logic [1:0]          lane;
      logic [1:0]          vsel;
      logic [LIGHT_IW-1:0] light;
   } ppls_cmd_type;

   typedef struct packed {
      logic [LCNT_W-1:0] light_total;
      logic              out_free;
   } ppls_status_type;

   function automatic logic [15:0] lane16(input logic [47:0] v, input logic [1:0] c);
      lane16 = v[16*c +: 16];
   endfunction

endpackage

// ===== rtl/ppls_datapath.sv =====
// Datapath: configuration, light table, shared multiplier, square root, divider, power unit.
module ppls_datapath import ppls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ppls_cmd_type      cmd,
   output ppls_status_type   status,
   input  req_type           req_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [47:0]       csr_wdata,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam int MAC_W = 52;

   logic [47:0] mat_ambient_ff, mat_diffuse_ff, mat_specular_ff, view_position_ff;
   logic [7:0]  shininess_ff;
   logic [3:0]  light_count_ff;

   logic [47:0] table_mem [TABLE_DEPTH];
   logic [47:0] rdata_ff;
   logic [1:0]  rd_word_ff;
   logic        rd_pend_ff;
   logic [47:0] light_ff [4];

   logic signed [15:0] frag_ff [3];
   logic signed [16:0] vec_ff [3];
   logic signed [15:0] nrm_ff [3];
   logic signed [15:0] view_ff [3];
   logic signed [15:0] lit_ff [3];
   logic signed [31:0] refl_ff [3];
   logic signed [MAC_W-1:0] mac_ff;
   logic        zero_ff;
   logic [59:0] sq_rem_ff, sq_root_ff, sq_bit_ff;
   logic [44:0] dv_rem_ff, dv_div_ff;
   logic [15:0] dv_q_ff;
   logic        dv_neg_ff;
   logic [14:0] diff_ff;
   logic [15:0] pw_base_ff, pw_acc_ff;
   logic [7:0]  pw_exp_ff;
   logic [31:0] prod_ff;
   logic [39:0] sum_ff [3];
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [59:0] sq_trial;
   logic signed [16:0] div_src;
   logic [16:0] div_mag;
   logic signed [15:0] unit_val;
   logic signed [MAC_W-1:0] spec_shift;
   logic [31:0] pw_pa, pw_pb;

   function automatic logic [7:0] to_byte(input logic [39:0] s);
      logic [37:0] p;
      p = {s[29:0], 8'd0} - 38'(s[29:0]);
      if (s >= 40'h00_4000_0000) begin
         to_byte = 8'hFF;
      end else begin
         to_byte = p[37:30];
      end
   endfunction

   // One shared multiplier; each operation picks its operands.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_SQUARE: begin
            mul_a = 33'(vec_ff[cmd.lane]);
            mul_b = 33'(vec_ff[cmd.lane]);
         end
         OP_DOT: begin
            mul_a = 33'(nrm_ff[cmd.lane]);
            mul_b = 33'(lit_ff[cmd.lane]);
         end
         OP_REFL: begin
            mul_a = $signed({18'd0, diff_ff});
            mul_b = 33'(nrm_ff[cmd.lane]);
         end
         OP_SPEC_DOT: begin
            mul_a = 33'(view_ff[cmd.lane]);
            mul_b = 33'(refl_ff[cmd.lane]);
         end
         OP_AMB_TERM: begin
            mul_a = $signed(33'(lane16(light_ff[WORD_AMBIENT], cmd.lane)));
            mul_b = $signed(33'(lane16(mat_ambient_ff, cmd.lane)));
         end
         OP_DIF_COLOR: begin
            mul_a = $signed(33'(lane16(light_ff[WORD_DIFFUSE], cmd.lane)));
            mul_b = $signed(33'(lane16(mat_diffuse_ff, cmd.lane)));
         end
         OP_DIF_TERM: begin
            mul_a = $signed({1'b0, prod_ff});
            mul_b = $signed({18'd0, diff_ff});
         end
         OP_SPC_COLOR: begin
            mul_a = $signed(33'(lane16(light_ff[WORD_SPECULAR], cmd.lane)));
            mul_b = $signed(33'(lane16(mat_specular_ff, cmd.lane)));
         end
         OP_SPC_TERM: begin
            mul_a = $signed({1'b0, prod_ff});
            mul_b = $signed({17'd0, pw_acc_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p      = mul_a * mul_b;
   assign sq_trial   = sq_root_ff + sq_bit_ff;
   assign div_src    = vec_ff[cmd.lane];
   assign div_mag    = (div_src < 0) ? 17'(-div_src) : 17'(div_src);
   assign unit_val   = zero_ff ? 16'sd0 :
                       (dv_neg_ff ? -$signed(dv_q_ff) : $signed(dv_q_ff));
   assign spec_shift = mac_ff >>> 27;
   assign pw_pa      = 32'(pw_acc_ff) * 32'(pw_base_ff);
   assign pw_pb      = 32'(pw_base_ff) * 32'(pw_base_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ambient_ff   <= '0;
         mat_diffuse_ff   <= '0;
         mat_specular_ff  <= '0;
         shininess_ff     <= 8'd32;
         view_position_ff <= '0;
         light_count_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAT_AMBIENT:   mat_ambient_ff   <= csr_wdata;
            CSR_MAT_DIFFUSE:   mat_diffuse_ff   <= csr_wdata;
            CSR_MAT_SPECULAR:  mat_specular_ff  <= csr_wdata;
            CSR_SHININESS:     shininess_ff     <= csr_wdata[7:0];
            CSR_VIEW_POSITION: view_position_ff <= csr_wdata;
            CSR_LIGHT_COUNT:   light_count_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Light table and its read pipeline.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_TABLE_WR && {29'd0, req_data.light_index} < 32'(MAX_LIGHTS)) begin
         table_mem[{LIGHT_IW'(req_data.light_index), req_data.light_word}]
            <= req_data.light_value;
      end
      if (cmd.op == OP_READ) begin
         rdata_ff <= table_mem[{cmd.light, cmd.lane}];
      end
      rd_word_ff <= cmd.lane;
      if (rd_pend_ff) begin
         light_ff[rd_word_ff] <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (cmd.op == OP_READ);
         if (cmd.op == OP_OUTPUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Arithmetic registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD_FRAG: begin
            frag_ff[0] <= req_data.frag_x;
            frag_ff[1] <= req_data.frag_y;
            frag_ff[2] <= req_data.frag_z;
            vec_ff[0]  <= 17'(req_data.normal_x);
            vec_ff[1]  <= 17'(req_data.normal_y);
            vec_ff[2]  <= 17'(req_data.normal_z);
         end
         OP_SET_VIEW: begin
            for (int i = 0; i < 3; i++) begin
               vec_ff[i] <= 17'(frag_ff[i])
                  - 17'($signed(lane16(view_position_ff, 2'(i))));
               sum_ff[i] <= '0;
            end
         end
         OP_SET_LIGHT: begin
            for (int i = 0; i < 3; i++) begin
               vec_ff[i] <= 17'($signed(lane16(light_ff[WORD_POSITION], 2'(i))))
                  - 17'(frag_ff[i]);
            end
         end
         OP_SQUARE, OP_DOT, OP_SPEC_DOT: begin
            mac_ff <= ((cmd.lane == 2'd0) ? '0 : mac_ff) + MAC_W'(mul_p);
         end
         OP_SQRT_INIT: begin
            zero_ff    <= (mac_ff == '0);
            sq_rem_ff  <= {mac_ff[33:0], 26'd0};
            sq_root_ff <= '0;
            sq_bit_ff  <= 60'd1 << 58;
         end
         OP_SQRT_STEP: begin
            if (sq_rem_ff >= sq_trial) begin
               sq_rem_ff  <= sq_rem_ff - sq_trial;
               sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
            end else begin
               sq_root_ff <= sq_root_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         OP_DIV_INIT: begin
            dv_neg_ff <= (div_src < 0);
            dv_rem_ff <= 45'(div_mag) << 27;
            dv_div_ff <= 45'(sq_root_ff[29:0]) << 15;
            dv_q_ff   <= '0;
         end
         OP_DIV_STEP: begin
            if (dv_rem_ff >= dv_div_ff) begin
               dv_rem_ff <= dv_rem_ff - dv_div_ff;
               dv_q_ff   <= {dv_q_ff[14:0], 1'b1};
            end else begin
               dv_q_ff   <= {dv_q_ff[14:0], 1'b0};
            end
            dv_div_ff <= dv_div_ff >> 1;
         end
         OP_DIV_STORE: begin
            unique case (cmd.vsel)
               VSEL_NORMAL: nrm_ff[cmd.lane]  <= unit_val;
               VSEL_VIEW:   view_ff[cmd.lane] <= unit_val;
               default:     lit_ff[cmd.lane]  <= unit_val;
            endcase
         end
         OP_DIFF: begin
            diff_ff <= (mac_ff > 0) ? 15'(mac_ff >>> 14) : 15'd0;
         end
         OP_REFL: begin
            refl_ff[cmd.lane] <= (32'(lit_ff[cmd.lane]) <<< 14) - (32'(mul_p) <<< 1);
         end
         OP_POW_INIT: begin
            if (mac_ff <= 0) begin
               pw_base_ff <= 16'd0;
            end else if (spec_shift > 32768) begin
               pw_base_ff <= 16'd32768;
            end else begin
               pw_base_ff <= spec_shift[15:0];
            end
            pw_acc_ff <= 16'd32768;
            pw_exp_ff <= shininess_ff;
         end
         OP_POW_STEP: begin
            if (pw_exp_ff[0]) begin
               pw_acc_ff <= pw_pa[30:15];
            end
            pw_base_ff <= pw_pb[30:15];
            pw_exp_ff  <= pw_exp_ff >> 1;
         end
         OP_AMB_TERM: begin
            sum_ff[cmd.lane] <= sum_ff[cmd.lane] + 40'(mul_p);
         end
         OP_DIF_COLOR, OP_SPC_COLOR: begin
            prod_ff <= mul_p[31:0];
         end
         OP_DIF_TERM: begin
            sum_ff[cmd.lane] <= sum_ff[cmd.lane] + 40'(mul_p >>> 14);
         end
         OP_SPC_TERM: begin
            // The specular term only counts for a light that faces the surface.
            if (diff_ff != '0) begin
               sum_ff[cmd.lane] <= sum_ff[cmd.lane] + 40'(mul_p >>> 15);
            end
         end
         OP_OUTPUT: begin
            rsp_data_ff.red   <= to_byte(sum_ff[0]);
            rsp_data_ff.green <= to_byte(sum_ff[1]);
            rsp_data_ff.blue  <= to_byte(sum_ff[2]);
         end
         default: ;
      endcase
   end

   assign status.light_total = (32'(light_count_ff) > MAX_LIGHTS) ?
                               LCNT_W'(MAX_LIGHTS) : LCNT_W'(light_count_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;

endmodule

// ===== rtl/ppls_ctrl.sv =====
// Controller: sequences the datapath through normalization and the per-light loop.
module ppls_ctrl import ppls_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_operation,
   output logic            req_ready,
   input  ppls_status_type status,
   output ppls_cmd_type    cmd
);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_SQUARE    = 5'd1;
   localparam logic [4:0] S_SQRT_INIT = 5'd2;
   localparam logic [4:0] S_SQRT      = 5'd3;
   localparam logic [4:0] S_DIV_INIT  = 5'd4;
   localparam logic [4:0] S_DIV       = 5'd5;
   localparam logic [4:0] S_DIV_STORE = 5'd6;
   localparam logic [4:0] S_SET_VIEW  = 5'd7;
   localparam logic [4:0] S_LCHECK    = 5'd8;
   localparam logic [4:0] S_LREAD     = 5'd9;
   localparam logic [4:0] S_SET_LIGHT = 5'd10;
   localparam logic [4:0] S_DOT       = 5'd11;
   localparam logic [4:0] S_DIFF      = 5'd12;
   localparam logic [4:0] S_REFL      = 5'd13;
   localparam logic [4:0] S_SPEC_DOT  = 5'd14;
   localparam logic [4:0] S_POW_INIT  = 5'd15;
   localparam logic [4:0] S_POW       = 5'd16;
   localparam logic [4:0] S_CHAN      = 5'd17;
   localparam logic [4:0] S_FINISH    = 5'd18;

   localparam logic [4:0] CH_AMB_TERM  = 5'd0;
   localparam logic [4:0] CH_DIF_COLOR = 5'd1;
   localparam logic [4:0] CH_DIF_TERM  = 5'd2;
   localparam logic [4:0] CH_SPC_COLOR = 5'd3;
   localparam logic [4:0] CH_SPC_TERM  = 5'd4;

   logic [4:0]        state_ff, state_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [1:0]        lane_ff, lane_in;
   logic [1:0]        vsel_ff, vsel_in;
   logic [LCNT_W-1:0] light_ff, light_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         lane_ff  <= '0;
         vsel_ff  <= VSEL_NORMAL;
         light_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         lane_ff  <= lane_in;
         vsel_ff  <= vsel_in;
         light_ff <= light_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lane_in   = lane_ff;
      vsel_in   = vsel_ff;
      light_in  = light_ff;
      req_ready = (state_ff == S_IDLE);
      cmd.op    = OP_NOP;
      cmd.lane  = lane_ff;
      cmd.vsel  = vsel_ff;
      cmd.light = light_ff[LIGHT_IW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == OPERATION_SHADE) begin
                  cmd.op   = OP_LOAD_FRAG;
                  vsel_in  = VSEL_NORMAL;
                  lane_in  = 2'd0;
                  state_in = S_SQUARE;
               end else begin
                  cmd.op = OP_TABLE_WR;
               end
            end
         end
         S_SQUARE: begin
            cmd.op = OP_SQUARE;
            if (lane_ff == 2'd2) begin
               lane_in  = 2'd0;
               state_in = S_SQRT_INIT;
            end else begin
               lane_in = lane_ff + 2'd1;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               state_in = S_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = S_DIV_STORE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_DIV_STORE: begin
            cmd.op = OP_DIV_STORE;
            if (lane_ff == 2'd2) begin
               lane_in = 2'd0;
               unique case (vsel_ff)
                  VSEL_NORMAL: state_in = S_SET_VIEW;
                  VSEL_VIEW: begin
                     light_in = '0;
                     state_in = S_LCHECK;
                  end
                  default: state_in = S_DOT;
               endcase
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = S_DIV_INIT;
            end
         end
         S_SET_VIEW: begin
            cmd.op   = OP_SET_VIEW;
            vsel_in  = VSEL_VIEW;
            state_in = S_SQUARE;
         end
         S_LCHECK: begin
            lane_in = 2'd0;
            if (light_ff < status.light_total) begin
               state_in = S_LREAD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LREAD: begin
            // The lane field selects the table word; four reads fill the light registers.
            cmd.op = OP_READ;
            if (lane_ff == WORD_SPECULAR) begin
               lane_in  = 2'd0;
               state_in = S_SET_LIGHT;
            end else begin
               lane_in = lane_ff + 2'd1;
            end
         end
         S_SET_LIGHT: begin
            cmd.op   = OP_SET_LIGHT;
            vsel_in  = VSEL_LIGHT;
            state_in = S_SQUARE;
         end
         S_DOT: begin
            cmd.op = OP_DOT;
            if (lane_ff == 2'd2) begin
               lane_in  = 2'd0;
               state_in = S_DIFF;
            end else begin
               lane_in = lane_ff + 2'd1;
            end
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = S_REFL;
         end
         S_REFL: begin
            cmd.op = OP_REFL;
            if (lane_ff == 2'd2) begin
               lane_in  = 2'd0;
               state_in = S_SPEC_DOT;
            end else begin
               lane_in = lane_ff + 2'd1;
            end
         end
         S_SPEC_DOT: begin
            cmd.op = OP_SPEC_DOT;
            if (lane_ff == 2'd2) begin
               lane_in  = 2'd0;
               state_in = S_POW_INIT;
            end else begin
               lane_in = lane_ff + 2'd1;
            end
         end
         S_POW_INIT: begin
            cmd.op   = OP_POW_INIT;
            cnt_in   = '0;
            state_in = S_POW;
         end
         S_POW: begin
            cmd.op = OP_POW_STEP;
            if (cnt_ff == 5'(POW_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_CHAN;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_CHAN: begin
            case (cnt_ff)
               CH_AMB_TERM:  cmd.op = OP_AMB_TERM;
               CH_DIF_COLOR: cmd.op = OP_DIF_COLOR;
               CH_DIF_TERM:  cmd.op = OP_DIF_TERM;
               CH_SPC_COLOR: cmd.op = OP_SPC_COLOR;
               default:      cmd.op = OP_SPC_TERM;
            endcase
            if (cnt_ff == CH_SPC_TERM) begin
               cnt_in = '0;
               if (lane_ff == 2'd2) begin
                  lane_in  = 2'd0;
                  light_in = light_ff + 1'b1;
                  state_in = S_LCHECK;
               end else begin
                  lane_in = lane_ff + 2'd1;
               end
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.op   = OP_OUTPUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/phong_point_light_shader_unit.sv =====
// Top level of the Phong point-light fragment shader.
// An item either writes one word of the light table or shades one fragment and yields
// one RGB result. Each fragment needs 2 + L vector normalizations, L being the active
// light count; each runs on the one-bit-per-cycle square root (30 steps) and restoring
// divider (16 steps per axis). Each light adds dot products and the color sums on the
// single shared multiplier, and an 8-step power unit with its own multipliers. The
// result waits in an output register, and the next item is accepted once the result
// has been loaded there.
module phong_point_light_shader_unit import ppls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [47:0]       csr_wdata
);

   ppls_cmd_type    cmd;
   ppls_status_type status;

   ppls_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   ppls_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
